>>> rtl/bec_pkg.sv
package bec_pkg;

	localparam int INDEX_W = 10;
	localparam int FIELD_W = 16;
	localparam int SLOTS_W = 6;
	localparam int CFG_IDX_W = 3;

	typedef enum logic {
		ACT_LOAD    = 1'b0,
		ACT_CORRECT = 1'b1
	} act_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_CLAMP = 2'd1,
		ST_ZERO  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		POS_IN   = 2'd0,
		POS_LOW  = 2'd1,
		POS_HIGH = 2'd2
	} pos_sel_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OFF_LO    = 3'd0,
		REG_OFF_HI    = 3'd1,
		REG_ANG_LO    = 3'd2,
		REG_ANG_HI    = 3'd3,
		REG_OFF_SLOTS = 3'd4,
		REG_ANG_SLOTS = 3'd5
	} cfg_reg_t;

	localparam logic signed [FIELD_W-1:0] OFF_LO_RST = -16'sd16384;
	localparam logic signed [FIELD_W-1:0] OFF_HI_RST = 16'sd16384;
	localparam logic signed [FIELD_W-1:0] ANG_LO_RST = -16'sd25736;
	localparam logic signed [FIELD_W-1:0] ANG_HI_RST = 16'sd25736;
	localparam logic [SLOTS_W-1:0] SLOTS_RST = 6'd32;

	typedef struct packed {
		act_t                 action;
		logic [INDEX_W-1:0]   index;
		logic [2*FIELD_W-1:0] data;
		logic                 zero;
		logic                 clamp;
	} meta_t;

endpackage

>>> rtl/bilinear_edge_correction_lookup.sv
// throughput: one request per cycle; the whole pipeline holds only while a result is stalled
// the position divider retires one quotient bit per stage and sets the depth
// reset clears the pipeline valids and restores the span and slot registers
// the correction table is not cleared; entries are defined once loaded
module bilinear_edge_correction_lookup #(
	parameter int MAX_OFFSET_SLOTS = 32,
	parameter int MAX_ANGLE_SLOTS  = 32,
	parameter int FRACTION_BITS    = 12
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  item_valid,
	output logic                                  item_stall,
	input  bec_pkg::act_t                         action,
	input  logic [bec_pkg::INDEX_W-1:0]           entry_index,
	input  logic signed [bec_pkg::FIELD_W-1:0]    edge_offset,
	input  logic signed [bec_pkg::FIELD_W-1:0]    edge_angle,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output logic signed [bec_pkg::FIELD_W-1:0]    corrected_offset,
	output logic signed [bec_pkg::FIELD_W-1:0]    corrected_angle,
	output bec_pkg::status_t                      status,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [bec_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [bec_pkg::FIELD_W-1:0]           cfg_data
);
	import bec_pkg::*;

	localparam int FB    = FRACTION_BITS;
	localparam int MAXS  = (MAX_OFFSET_SLOTS > MAX_ANGLE_SLOTS) ?
		MAX_OFFSET_SLOTS : MAX_ANGLE_SLOTS;
	localparam int SW    = $clog2(MAXS);
	localparam int QW    = SW + FB;
	localparam int DL    = 1 + QW;
	localparam int DEPTH = MAX_OFFSET_SLOTS * MAX_ANGLE_SLOTS;
	localparam int AW    = $clog2(DEPTH);
	localparam int SLW   = $clog2(MAXS + 1);
	localparam logic [FB:0] ONE  = (FB+1)'(1) << FB;
	localparam logic [FB:0] HALF = (FB+1)'(1) << (FB - 1);

	typedef struct packed {
		logic [15:0] num;
		logic [15:0] den;
		pos_sel_t    sel;
		logic        zero;
	} axis_t;

	// configuration
	logic signed [FIELD_W-1:0] off_lo_q, off_hi_q, ang_lo_q, ang_hi_q;
	logic [SLOTS_W-1:0]        off_slots_q, ang_slots_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_lo_q    <= OFF_LO_RST;
			off_hi_q    <= OFF_HI_RST;
			ang_lo_q    <= ANG_LO_RST;
			ang_hi_q    <= ANG_HI_RST;
			off_slots_q <= SLOTS_RST;
			ang_slots_q <= SLOTS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_OFF_LO:    off_lo_q    <= cfg_data;
				REG_OFF_HI:    off_hi_q    <= cfg_data;
				REG_ANG_LO:    ang_lo_q    <= cfg_data;
				REG_ANG_HI:    ang_hi_q    <= cfg_data;
				REG_OFF_SLOTS: off_slots_q <= cfg_data[SLOTS_W-1:0];
				REG_ANG_SLOTS: ang_slots_q <= cfg_data[SLOTS_W-1:0];
				default: ;
			endcase
		end
	end

	function automatic logic [SLW-1:0] eff_slots(logic [SLOTS_W-1:0] s, int mx);
		if (s == '0) return SLW'(1);
		if (32'(s) > mx) return SLW'(mx);
		return SLW'(s);
	endfunction

	function automatic axis_t map_axis(logic signed [15:0] x, logic signed [15:0] lo,
		logic signed [15:0] hi);
		logic signed [17:0] n;
		logic signed [17:0] d;
		axis_t r;
		n = 18'(x) - 18'(lo);
		d = 18'(hi) - 18'(lo);
		if (d < 0) begin
			n = -n;
			d = -d;
		end
		r.zero = (d == 0);
		r.num  = n[15:0];
		r.den  = d[15:0];
		if (n < 0) r.sel = POS_LOW;
		else if (n > d) r.sel = POS_HIGH;
		else r.sel = POS_IN;
		return r;
	endfunction

	function automatic logic signed [15:0] blend(logic signed [15:0] a,
		logic signed [15:0] b, logic [FB-1:0] f);
		logic [FB:0] wa;
		logic signed [FB+17:0] v;
		wa = ONE - {1'b0, f};
		v = (FB+18)'(a) * $signed({1'b0, wa}) + (FB+18)'(b) * $signed({2'b0, f})
			+ $signed({17'b0, HALF});
		return 16'(v >>> FB);
	endfunction

	logic [SLW-1:0] ns, as;
	assign ns = eff_slots(off_slots_q, MAX_OFFSET_SLOTS);
	assign as = eff_slots(ang_slots_q, MAX_ANGLE_SLOTS);

	logic en;
	logic result_valid_q;
	assign en         = !result_valid_q || !result_stall;
	assign item_stall = !en;

	// stage 1: span mapping
	axis_t ax_o, ax_a;
	assign ax_o = map_axis(edge_offset, off_lo_q, off_hi_q);
	assign ax_a = map_axis(edge_angle, ang_lo_q, ang_hi_q);

	axis_t ax_o_s1, ax_a_s1;
	meta_t md [0:DL];
	logic [DL:0] vd;

	always_ff @(posedge clk) begin
		if (en) begin
			ax_o_s1     <= ax_o;
			ax_a_s1     <= ax_a;
			md[0].action <= action;
			md[0].index  <= entry_index;
			md[0].data   <= {edge_angle, edge_offset};
			md[0].zero   <= ax_o.zero || ax_a.zero;
			md[0].clamp  <= (ax_o.sel != POS_IN) || (ax_a.sel != POS_IN);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vd <= '0;
		end else if (en) begin
			vd <= {vd[DL-1:0], item_valid};
		end
	end

	for (genvar k = 1; k <= DL; k++) begin : g_meta
		always_ff @(posedge clk) begin
			if (en) md[k] <= md[k-1];
		end
	end

	// position dividers
	logic [QW-1:0] po, pa;

	bec_div #(.SW(SW), .FB(FB)) u_div_off (
		.clk   (clk),
		.en    (en),
		.num   (ax_o_s1.num),
		.den   (ax_o_s1.den),
		.scale (SW'(ns - SLW'(1))),
		.sel   (ax_o_s1.sel),
		.pos   (po)
	);

	bec_div #(.SW(SW), .FB(FB)) u_div_ang (
		.clk   (clk),
		.en    (en),
		.num   (ax_a_s1.num),
		.den   (ax_a_s1.den),
		.scale (SW'(as - SLW'(1))),
		.sel   (ax_a_s1.sel),
		.pos   (pa)
	);

	// stage A: index split
	logic [SW-1:0] olo_s2, ohi_s2, alo_s2, ahi_s2;
	logic [FB-1:0] fo_s2, fa_s2;
	meta_t         meta_s2;
	logic          v_s2;

	// stage B: addresses
	logic [AW-1:0] addr_s3 [4];
	logic [FB-1:0] fo_s3, fa_s3;
	meta_t         meta_s3;
	logic          v_s3;

	// stage C: table read
	logic [31:0]   rd_s4 [4];
	logic [FB-1:0] fo_s4, fa_s4;
	meta_t         meta_s4;
	logic          v_s4;

	// stage D: blend along offset
	logic signed [15:0] top_off_s5, top_ang_s5, bot_off_s5, bot_ang_s5;
	logic [FB-1:0]      fa_s5;
	meta_t              meta_s5;
	logic               v_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			olo_s2  <= po[QW-1:FB];
			ohi_s2  <= po[QW-1:FB] + SW'(po[FB-1:0] != '0);
			fo_s2   <= po[FB-1:0];
			alo_s2  <= pa[QW-1:FB];
			ahi_s2  <= pa[QW-1:FB] + SW'(pa[FB-1:0] != '0);
			fa_s2   <= pa[FB-1:0];
			meta_s2 <= md[DL];

			addr_s3[0] <= AW'(32'(olo_s2) * 32'(as) + 32'(alo_s2));
			addr_s3[1] <= AW'(32'(ohi_s2) * 32'(as) + 32'(alo_s2));
			addr_s3[2] <= AW'(32'(olo_s2) * 32'(as) + 32'(ahi_s2));
			addr_s3[3] <= AW'(32'(ohi_s2) * 32'(as) + 32'(ahi_s2));
			fo_s3      <= fo_s2;
			fa_s3      <= fa_s2;
			meta_s3    <= meta_s2;

			fo_s4   <= fo_s3;
			fa_s4   <= fa_s3;
			meta_s4 <= meta_s3;

			top_off_s5 <= blend(rd_s4[0][15:0], rd_s4[1][15:0], fo_s4);
			top_ang_s5 <= blend(rd_s4[0][31:16], rd_s4[1][31:16], fo_s4);
			bot_off_s5 <= blend(rd_s4[2][15:0], rd_s4[3][15:0], fo_s4);
			bot_ang_s5 <= blend(rd_s4[2][31:16], rd_s4[3][31:16], fo_s4);
			fa_s5      <= fa_s4;
			meta_s5    <= meta_s4;
		end
	end

	// table: one copy per neighbor, loads write all copies
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	assign wr_en   = en && v_s3 && (meta_s3.action == ACT_LOAD) &&
		(32'(meta_s3.index) < DEPTH);
	assign wr_addr = AW'(32'(meta_s3.index));

	for (genvar g = 0; g < 4; g++) begin : g_bank
		logic [31:0] mem [DEPTH];
		always_ff @(posedge clk) begin
			if (wr_en) mem[wr_addr] <= meta_s3.data;
			if (en) rd_s4[g] <= mem[addr_s3[g]];
		end
	end

	// stage E: blend along angle, result register
	logic signed [15:0] corrected_offset_q, corrected_angle_q;
	status_t            status_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (meta_s5.action == ACT_LOAD) begin
				corrected_offset_q <= '0;
				corrected_angle_q  <= '0;
				status_q           <= ST_OK;
			end else if (meta_s5.zero) begin
				corrected_offset_q <= '0;
				corrected_angle_q  <= '0;
				status_q           <= ST_ZERO;
			end else begin
				corrected_offset_q <= blend(top_off_s5, bot_off_s5, fa_s5);
				corrected_angle_q  <= blend(top_ang_s5, bot_ang_s5, fa_s5);
				status_q           <= meta_s5.clamp ? ST_CLAMP : ST_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2           <= 1'b0;
			v_s3           <= 1'b0;
			v_s4           <= 1'b0;
			v_s5           <= 1'b0;
			result_valid_q <= 1'b0;
		end else if (en) begin
			v_s2           <= vd[DL];
			v_s3           <= v_s2;
			v_s4           <= v_s3;
			v_s5           <= v_s4;
			result_valid_q <= v_s5;
		end
	end

	assign result_valid     = result_valid_q;
	assign corrected_offset = corrected_offset_q;
	assign corrected_angle  = corrected_angle_q;
	assign status           = status_q;

	a_stall_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (result_valid && result_stall))
		else $error("request stalled while result path free");

	a_zero_span_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status == ST_ZERO) |->
		(corrected_offset == '0 && corrected_angle == '0))
		else $error("zero-width span result not cleared");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (status == ST_OK || status == ST_CLAMP || status == ST_ZERO))
		else $error("bad status code");

	a_pipe_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(!item_stall && v_s5) |=> result_valid)
		else $error("pipeline lost a result");

endmodule

>>> rtl/bec_div.sv
module bec_div #(
	parameter int SW = 5,
	parameter int FB = 12
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [15:0]          num,
	input  logic [15:0]          den,
	input  logic [SW-1:0]        scale,
	input  bec_pkg::pos_sel_t    sel,
	output logic [SW+FB-1:0]     pos
);
	import bec_pkg::*;

	localparam int QW = SW + FB;
	localparam int PW = 16 + SW;

	logic [PW-1:0] prod_s [0:QW];
	logic [15:0]   den_s  [0:QW];
	logic [SW-1:0] scale_s [0:QW];
	pos_sel_t      sel_s  [0:QW];
	logic [15:0]   rem_s  [1:QW];
	logic [QW-1:0] q_s    [1:QW];

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s[0]  <= PW'(num) * PW'(scale);
			den_s[0]   <= den;
			scale_s[0] <= scale;
			sel_s[0]   <= sel;
		end
	end

	// one quotient bit per stage, restoring
	for (genvar i = 0; i < QW; i++) begin : g_step
		logic [15:0]   r_in;
		logic [QW-1:0] q_in;
		logic          b_in;
		logic [16:0]   r2;
		logic          ge;

		if (i == 0) begin : g_first
			assign r_in = prod_s[0][PW-1:SW];
			assign q_in = '0;
		end else begin : g_next
			assign r_in = rem_s[i];
			assign q_in = q_s[i];
		end

		if (i < SW) begin : g_bit
			assign b_in = prod_s[i][SW-1-i];
		end else begin : g_zero
			assign b_in = 1'b0;
		end

		assign r2 = {r_in, b_in};
		assign ge = r2 >= {1'b0, den_s[i]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]   <= ge ? 16'(r2 - {1'b0, den_s[i]}) : r2[15:0];
				q_s[i+1]     <= {q_in[QW-2:0], ge};
				prod_s[i+1]  <= prod_s[i];
				den_s[i+1]   <= den_s[i];
				scale_s[i+1] <= scale_s[i];
				sel_s[i+1]   <= sel_s[i];
			end
		end
	end

	always_comb begin
		case (sel_s[QW])
			POS_LOW:  pos = '0;
			POS_HIGH: pos = {scale_s[QW], {FB{1'b0}}};
			default:  pos = q_s[QW];
		endcase
	end

endmodule

>>> tb/bilinear_edge_correction_lookup_tb.sv
`timescale 1ns / 1ps

module bilinear_edge_correction_lookup_tb;
	import bec_pkg::*;

	localparam int DEPTH = 1024;
	localparam int FB = 12;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct packed {
		logic signed [15:0] off;
		logic signed [15:0] ang;
		status_t            st;
	} edge_result_t;

	class bec_scoreboard;
		logic [31:0] entries [DEPTH];
		logic signed [15:0] off_lo, off_hi, ang_lo, ang_hi;
		logic [5:0] off_slots, ang_slots;
		edge_result_t pending_results [$];
		int n_load, n_correct, n_clamp, n_zero;

		function new();
			off_lo = OFF_LO_RST;
			off_hi = OFF_HI_RST;
			ang_lo = ANG_LO_RST;
			ang_hi = ANG_HI_RST;
			off_slots = SLOTS_RST;
			ang_slots = SLOTS_RST;
		endfunction

		function void write_register(cfg_reg_t r, logic [15:0] d);
			case (r)
				REG_OFF_LO: off_lo = d;
				REG_OFF_HI: off_hi = d;
				REG_ANG_LO: ang_lo = d;
				REG_ANG_HI: ang_hi = d;
				REG_OFF_SLOTS: off_slots = d[5:0];
				REG_ANG_SLOTS: ang_slots = d[5:0];
				default: ;
			endcase
		endfunction

		function int used_slots(logic [5:0] s);
			if (s == 0) return 1;
			if (s > 32) return 32;
			return int'(s);
		endfunction

		function longint axis_pos(int x, int lo, int hi, int s, inout bit clamped,
				inout bit zero_w);
			longint num, den;
			num = longint'(x) - lo;
			den = longint'(hi) - lo;
			if (den == 0) begin
				zero_w = 1;
				return 0;
			end
			if (den < 0) begin
				num = -num;
				den = -den;
			end
			if (num < 0) begin
				clamped = 1;
				return 0;
			end
			if (num > den) begin
				clamped = 1;
				return longint'(s - 1) << FB;
			end
			return ((num * (s - 1)) << FB) / den;
		endfunction

		function int mix(int a, int b, int f);
			longint v;
			v = longint'(a) * ((1 << FB) - f) + longint'(b) * f + (1 << (FB - 1));
			return int'(v >>> FB);
		endfunction

		function void note_request(act_t a, logic [9:0] idx, logic signed [15:0] x_off,
				logic signed [15:0] x_ang);
			edge_result_t r;
			bit clamped, zero_w;
			int ns, as_n, olo, ohi, alo, ahi, fo, fa;
			longint po, pa;
			logic [31:0] e00, e10, e01, e11;
			int t_off, t_ang, b_off, b_ang;
			r = '{off: 0, ang: 0, st: ST_OK};
			clamped = 0;
			zero_w = 0;
			if (a == ACT_LOAD) begin
				entries[idx] = {x_ang, x_off};
				n_load++;
				pending_results = {pending_results, r};
				return;
			end
			n_correct++;
			ns = used_slots(off_slots);
			as_n = used_slots(ang_slots);
			po = axis_pos(x_off, off_lo, off_hi, ns, clamped, zero_w);
			pa = axis_pos(x_ang, ang_lo, ang_hi, as_n, clamped, zero_w);
			if (zero_w) begin
				r.st = ST_ZERO;
				n_zero++;
				pending_results = {pending_results, r};
				return;
			end
			olo = int'(po >> FB);
			fo = int'(po) & ((1 << FB) - 1);
			ohi = fo != 0 ? olo + 1 : olo;
			alo = int'(pa >> FB);
			fa = int'(pa) & ((1 << FB) - 1);
			ahi = fa != 0 ? alo + 1 : alo;
			e00 = entries[(olo * as_n + alo) % DEPTH];
			e10 = entries[(ohi * as_n + alo) % DEPTH];
			e01 = entries[(olo * as_n + ahi) % DEPTH];
			e11 = entries[(ohi * as_n + ahi) % DEPTH];
			t_off = mix(int'($signed(e00[15:0])), int'($signed(e10[15:0])), fo);
			t_ang = mix(int'($signed(e00[31:16])), int'($signed(e10[31:16])), fo);
			b_off = mix(int'($signed(e01[15:0])), int'($signed(e11[15:0])), fo);
			b_ang = mix(int'($signed(e01[31:16])), int'($signed(e11[31:16])), fo);
			r.off = 16'(mix(t_off, b_off, fa));
			r.ang = 16'(mix(t_ang, b_ang, fa));
			r.st = clamped ? ST_CLAMP : ST_OK;
			if (clamped) n_clamp++;
			pending_results = {pending_results, r};
		endfunction

		// 0 match, 1 nothing outstanding, 2 field mismatch
		function int check_result(edge_result_t got, output edge_result_t exp);
			exp = '0;
			if (pending_results.size() == 0) return 1;
			exp = pending_results.pop_front();
			return got == exp ? 0 : 2;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	act_t action = ACT_LOAD;
	logic [INDEX_W-1:0] entry_index = '0;
	logic signed [FIELD_W-1:0] edge_offset = '0;
	logic signed [FIELD_W-1:0] edge_angle = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic signed [FIELD_W-1:0] corrected_offset;
	logic signed [FIELD_W-1:0] corrected_angle;
	status_t status;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_reg_t cfg_index = REG_OFF_LO;
	logic [FIELD_W-1:0] cfg_data = '0;

	bec_scoreboard sb = new();
	int errors = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	int stall_mode = 0;
	int stall_count = 0;

	bilinear_edge_correction_lookup dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.action(action), .entry_index(entry_index),
		.edge_offset(edge_offset), .edge_angle(edge_angle),
		.result_valid(result_valid), .result_stall(result_stall),
		.corrected_offset(corrected_offset), .corrected_angle(corrected_angle),
		.status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	task automatic report(string what, int got, int exp);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, exp);
		errors++;
	endtask

	// receiver stall pattern, switching at random among four modes
	always @(negedge clk) begin
		stall_count <= stall_count + 1;
		if (stall_count % 64 == 0) stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: result_stall <= 1'b0;
			1: result_stall <= $urandom_range(0, 3) == 0;
			2: result_stall <= $urandom_range(0, 9) < 7;
			default: result_stall <= stall_count % 3 == 0;
		endcase
	end

	always @(posedge clk) begin
		edge_result_t got, exp;
		int code;
		if (arst_n && result_valid && !result_stall) begin
			got = '{off: corrected_offset, ang: corrected_angle, st: status};
			code = sb.check_result(got, exp);
			if (code == 1) begin
				report("unexpected result, status", int'(status), -1);
			end else if (code == 2) begin
				if (got.off != exp.off) report("corrected_offset", got.off, exp.off);
				if (got.ang != exp.ang) report("corrected_angle", got.ang, exp.ang);
				if (got.st != exp.st) report("status", int'(got.st), int'(exp.st));
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", idle_cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send(act_t a, logic [9:0] idx, logic [15:0] off, logic [15:0] ang);
		if (burst_left == 0) begin
			item_valid = 1'b0;
			if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		action = a;
		entry_index = idx;
		edge_offset = off;
		edge_angle = ang;
		item_valid = 1'b1;
		do @(posedge clk); while (item_stall);
		sb.note_request(a, idx, off, ang);
		@(negedge clk);
	endtask

	task automatic settle();
		item_valid = 1'b0;
		while (sb.pending_results.size() > 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t r, logic [15:0] d);
		cfg_index = r;
		cfg_data = d;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.write_register(r, d);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic configure(int olo, int ohi, int alo, int ahi, int os, int as_n);
		settle();
		write_reg(REG_OFF_LO, 16'(olo));
		write_reg(REG_OFF_HI, 16'(ohi));
		write_reg(REG_ANG_LO, 16'(alo));
		write_reg(REG_ANG_HI, 16'(ahi));
		// upper bits beyond the slot field are don't-care
		write_reg(REG_OFF_SLOTS, {10'($urandom), 6'(os)});
		write_reg(REG_ANG_SLOTS, {10'($urandom), 6'(as_n)});
	endtask

	function automatic logic [15:0] pick(int lo, int hi);
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return 16'(lo);
		if (r == 1) return 16'(hi);
		if (r < 15) begin
			if (lo <= hi) return 16'(lo + int'($urandom_range(0, hi - lo)));
			return 16'(hi + int'($urandom_range(0, lo - hi)));
		end
		return 16'($urandom);
	endfunction

	task automatic run_batch(int n);
		repeat (n) begin
			if ($urandom_range(0, 6) == 0)
				send(ACT_LOAD, 10'($urandom), 16'($urandom), 16'($urandom));
			else
				send(ACT_CORRECT, 10'($urandom), pick(sb.off_lo, sb.off_hi),
					pick(sb.ang_lo, sb.ang_hi));
		end
	endtask

	initial begin
		int lo, hi;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// fill the whole table so no correction can read an empty entry
		for (int i = 0; i < DEPTH; i++)
			send(ACT_LOAD, 10'(i), 16'($urandom), 16'($urandom));

		send(ACT_LOAD, 10'd0, 16'h8000, 16'h7fff);
		send(ACT_LOAD, 10'd1023, 16'h7fff, 16'h8000);
		send(ACT_LOAD, 10'd33, 16'hffff, 16'h0000);
		send(ACT_CORRECT, '0, -16'sd16384, -16'sd25736);
		send(ACT_CORRECT, '0, 16'sd16384, 16'sd25736);
		send(ACT_CORRECT, '0, -16'sd16385, 16'sd0);
		send(ACT_CORRECT, '0, 16'sd0, 16'sd25737);
		send(ACT_CORRECT, '0, 16'h8000, 16'h7fff);
		send(ACT_CORRECT, '0, 16'h7fff, 16'h8000);
		send(ACT_CORRECT, '0, 16'sd0, 16'sd0);
		send(ACT_CORRECT, '0, 16'sd1, -16'sd1);
		send(ACT_CORRECT, 10'h3ff, 16'sd512, 16'sd804);

		configure(-16384, 16384, -25736, 25736, 32, 32);
		run_batch(12);
		configure(16384, -16384, 25736, -25736, 32, 32);
		run_batch(12);
		configure(-1000, 1000, -2000, 2000, 1, 1);
		run_batch(10);
		configure(-16384, 16384, -25736, 25736, 0, 63);
		run_batch(10);
		configure(500, 500, -25736, 25736, 32, 32);
		run_batch(8);
		configure(-16384, 16384, -300, -300, 17, 5);
		run_batch(8);
		configure(-16384, -16383, 25735, 25736, 2, 2);
		run_batch(10);
		configure(0, 16384, -25736, 0, 33, 31);
		run_batch(12);
		repeat (3) begin
			lo = $urandom_range(0, 32768) - 16384;
			hi = $urandom_range(0, 32768) - 16384;
			configure(lo, hi, $urandom_range(0, 51472) - 25736,
				$urandom_range(0, 51472) - 25736,
				$urandom_range(1, 32), $urandom_range(1, 32));
			run_batch(10);
		end

		settle();
		$display("covered %0d loads and %0d corrections over 11 span/slot settings",
			sb.n_load, sb.n_correct);
		$display("corrections clamped: %0d, zero-width: %0d", sb.n_clamp, sb.n_zero);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
